>>> rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types, codes and defaults of the range partition request steering
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

	// defaults for the top-level parameters
	localparam int MAX_SERVERS_DEF = 16;
	localparam int QUEUE_SLOTS_DEF = 256;

	// a scan never yields more results than this
	localparam int RESULT_CAP = 16;

	// front to back queue depth
	localparam int FIFO_DEPTH = 2;

	// register indexes of the configuration port
	localparam logic [1:0] CFG_SERVER_COUNT    = 2'd0;
	localparam logic [1:0] CFG_BASE_PORT       = 2'd1;
	localparam logic [1:0] CFG_KEYS_PER_SERVER = 2'd2;

	// reset values of the registers
	localparam logic [4:0]  SERVER_COUNT_RST    = 5'd1;
	localparam logic [15:0] BASE_PORT_RST       = 16'd1111;
	localparam logic [63:0] KEYS_PER_SERVER_RST = 64'hFFFF_FFFF_FFFF_FFFF;

	// input commands
	localparam logic [1:0] CMD_POINT = 2'd0;
	localparam logic [1:0] CMD_SCAN  = 2'd1;
	localparam logic [1:0] CMD_POP   = 2'd2;

	// result verdicts
	localparam logic [2:0] V_ENQ       = 3'd0;
	localparam logic [2:0] V_FULL      = 3'd1;
	localparam logic [2:0] V_BAD_PORT  = 3'd2;
	localparam logic [2:0] V_POPPED    = 3'd3;
	localparam logic [2:0] V_EMPTY     = 3'd4;
	localparam logic [2:0] V_BAD_RANGE = 3'd5;

	// classification made by the front
	typedef enum logic [2:0] {
		K_POINT,
		K_POINT_BAD,
		K_SCAN,
		K_SCAN_BAD,
		K_POP,
		K_POP_OOR
	} kind_t;

	// one classified word handed from front to back
	typedef struct packed {
		kind_t       kind;
		logic [3:0]  first;
		logic [3:0]  last;
		logic [63:0] s_lo;
		logic [63:0] s_hi;
		logic [63:0] e_lo;
		logic [63:0] e_hi;
		logic [63:0] step;
		logic [31:0] lim;
	} entry_t;

	// front sequencer states
	typedef enum logic [2:0] {
		F_IDLE,
		F_S_GO,
		F_S_WT,
		F_E_GO,
		F_E_WT,
		F_T_GO,
		F_T_WT,
		F_PUSH
	} fstate_t;

endpackage

`default_nettype wire

>>> rtl/range_partition_request_steering.sv
// ----------------------------------------------------------------------------
// range_partition_request_steering
// Steers point and range scan requests to per-server ring queues.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one request word; the output channel
// (out_valid/out_stall) delivers result words, each sub-scan of a range scan
// as its own word, last_of_run marking the final one. The config channel
// (cfg_valid/cfg_ready, ready always high) writes server_count, base_port and
// keys_per_server; write it only while the block is idle.
// Point and pop requests: the front stalls its input until it has pushed the
// word into the queue, and the back registers the result word. A range scan
// runs the shared 64-bit bit-serial divider up to three times (start server,
// end server, sub-range step) in the front, then the back emits one sub-scan
// word per cycle while out_stall is low. A scan with zero keys_per_server
// skips the two key divisions. A two-word queue parts front and back, so the
// front takes the next request while the back still drains or waits on
// out_stall. A stalled result word holds until taken.
// Reset clears all ring heads and tails and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module range_partition_request_steering #(
	parameter int MAX_SERVERS = rps_pkg::MAX_SERVERS_DEF,
	parameter int QUEUE_SLOTS = rps_pkg::QUEUE_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] dest_port,
	input  wire logic [63:0] start_key_lo,
	input  wire logic [63:0] start_key_hi,
	input  wire logic [63:0] end_key_lo,
	input  wire logic [63:0] end_key_hi,
	input  wire logic [31:0] item_limit,
	input  wire logic [3:0]  worker_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       server_index,
	output logic [63:0]      sub_start_lo,
	output logic [63:0]      sub_start_hi,
	output logic [63:0]      sub_end_lo,
	output logic [63:0]      sub_end_hi,
	output logic [31:0]      sub_item_limit,
	output logic [2:0]       verdict,
	output logic [7:0]       slot,
	output logic             last_of_run
);

	logic [4:0]  server_count_q;
	logic [15:0] base_port_q;
	logic [63:0] keys_per_server_q;

	logic            push, full, nonempty, pop;
	rps_pkg::entry_t push_entry, head;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q    <= rps_pkg::SERVER_COUNT_RST;
			base_port_q       <= rps_pkg::BASE_PORT_RST;
			keys_per_server_q <= rps_pkg::KEYS_PER_SERVER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rps_pkg::CFG_SERVER_COUNT:    server_count_q    <= cfg_data[4:0];
				rps_pkg::CFG_BASE_PORT:       base_port_q       <= cfg_data[15:0];
				rps_pkg::CFG_KEYS_PER_SERVER: keys_per_server_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rps_front #(.MAX_SERVERS(MAX_SERVERS)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.dest_port       (dest_port),
		.start_key_lo    (start_key_lo),
		.start_key_hi    (start_key_hi),
		.end_key_lo      (end_key_lo),
		.end_key_hi      (end_key_hi),
		.item_limit      (item_limit),
		.worker_index    (worker_index),
		.server_count    (server_count_q),
		.base_port       (base_port_q),
		.keys_per_server (keys_per_server_q),
		.push            (push),
		.push_entry      (push_entry),
		.fifo_full       (full)
	);

	rps_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.nonempty   (nonempty),
		.head       (head)
	);

	rps_back #(.MAX_SERVERS(MAX_SERVERS), .QUEUE_SLOTS(QUEUE_SLOTS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.nonempty       (nonempty),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.server_index   (server_index),
		.sub_start_lo   (sub_start_lo),
		.sub_start_hi   (sub_start_hi),
		.sub_end_lo     (sub_end_lo),
		.sub_end_hi     (sub_end_hi),
		.sub_item_limit (sub_item_limit),
		.verdict        (verdict),
		.slot           (slot),
		.last_of_run    (last_of_run)
	);

endmodule

`default_nettype wire

>>> rtl/rps_div.sv
// ----------------------------------------------------------------------------
// rps_div
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] shifted;
	logic [64:0] trial;

	// one trial subtract per cycle
	assign shifted = {rem_q, quo_q[63]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= trial[64] ? shifted[63:0] : trial[63:0];
			quo_q <= {quo_q[62:0], ~trial[64]};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/rps_front.sv
// ----------------------------------------------------------------------------
// rps_front
// Accepts request words, maps scan keys to servers with the shared divider
// and pushes one classified word into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_front #(
	parameter int MAX_SERVERS = rps_pkg::MAX_SERVERS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [1:0]      cmd,
	input  wire logic [15:0]     dest_port,
	input  wire logic [63:0]     start_key_lo,
	input  wire logic [63:0]     start_key_hi,
	input  wire logic [63:0]     end_key_lo,
	input  wire logic [63:0]     end_key_hi,
	input  wire logic [31:0]     item_limit,
	input  wire logic [3:0]      worker_index,
	input  wire logic [4:0]      server_count,
	input  wire logic [15:0]     base_port,
	input  wire logic [63:0]     keys_per_server,
	output logic                 push,
	output rps_pkg::entry_t      push_entry,
	input  wire logic            fifo_full
);

	localparam int DEPTH = (MAX_SERVERS < rps_pkg::RESULT_CAP) ?
		MAX_SERVERS : rps_pkg::RESULT_CAP;

	rps_pkg::fstate_t state_q, state_nx;

	logic [1:0]  cmd_q;
	logic [15:0] port_q;
	logic [63:0] s_lo_q, s_hi_q, e_lo_q, e_hi_q, step_q;
	logic [31:0] lim_q;
	logic [3:0]  wrk_q;
	logic [3:0]  first_q, last_q;

	logic [4:0]  n_act;
	logic [3:0]  n_m1;
	logic        acc;
	logic        div_start, div_done;
	logic [63:0] div_a, div_b, div_quo;
	logic [3:0]  clamp_q;
	logic [4:0]  split;
	logic [15:0] port_off;

	// servers in use: zero acts as one, capped at the queue count
	always_comb begin
		if (server_count == 5'd0) n_act = 5'd1;
		else if (server_count > 5'(DEPTH)) n_act = 5'(DEPTH);
		else n_act = server_count;
	end
	assign n_m1 = 4'(n_act - 5'd1);

	assign acc = in_valid && !in_stall;

	// divider quotient clamped to the last server
	assign clamp_q = (div_quo >= {59'd0, n_act}) ? n_m1 : div_quo[3:0];
	assign split   = {1'b0, last_q} - {1'b0, first_q} + 5'd1;

	// divider operands
	always_comb begin
		case (state_q)
			rps_pkg::F_T_GO: begin
				div_a = e_lo_q - s_lo_q;
				div_b = {59'd0, split};
			end
			rps_pkg::F_E_GO: begin
				div_a = e_lo_q;
				div_b = keys_per_server;
			end
			default: begin
				div_a = s_lo_q;
				div_b = keys_per_server;
			end
		endcase
	end

	rps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rps_pkg::F_IDLE: begin
				if (acc) begin
					case (cmd)
						rps_pkg::CMD_POINT: state_nx = rps_pkg::F_PUSH;
						rps_pkg::CMD_POP:   state_nx = rps_pkg::F_PUSH;
						rps_pkg::CMD_SCAN:  state_nx = (keys_per_server == 64'd0) ?
							rps_pkg::F_T_GO : rps_pkg::F_S_GO;
						default:            state_nx = rps_pkg::F_IDLE;
					endcase
				end
			end
			rps_pkg::F_S_GO: state_nx = rps_pkg::F_S_WT;
			rps_pkg::F_S_WT: if (div_done) state_nx = rps_pkg::F_E_GO;
			rps_pkg::F_E_GO: state_nx = rps_pkg::F_E_WT;
			rps_pkg::F_E_WT: begin
				if (div_done) state_nx = (clamp_q < first_q) ?
					rps_pkg::F_PUSH : rps_pkg::F_T_GO;
			end
			rps_pkg::F_T_GO: state_nx = rps_pkg::F_T_WT;
			rps_pkg::F_T_WT: if (div_done) state_nx = rps_pkg::F_PUSH;
			rps_pkg::F_PUSH: if (!fifo_full) state_nx = rps_pkg::F_IDLE;
			default:         state_nx = rps_pkg::F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = (state_q != rps_pkg::F_IDLE);
		push      = (state_q == rps_pkg::F_PUSH) && !fifo_full;
		div_start = (state_q == rps_pkg::F_S_GO) || (state_q == rps_pkg::F_E_GO) ||
			(state_q == rps_pkg::F_T_GO);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rps_pkg::F_IDLE;
		else state_q <= state_nx;
	end

	// request capture and server mapping
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q   <= cmd;
			port_q  <= dest_port;
			s_lo_q  <= start_key_lo;
			s_hi_q  <= start_key_hi;
			e_lo_q  <= end_key_lo;
			e_hi_q  <= end_key_hi;
			lim_q   <= item_limit;
			wrk_q   <= worker_index;
			first_q <= n_m1;
			last_q  <= n_m1;
		end
		if (state_q == rps_pkg::F_S_WT && div_done) first_q <= clamp_q;
		if (state_q == rps_pkg::F_E_WT && div_done) last_q  <= clamp_q;
		if (state_q == rps_pkg::F_T_WT && div_done) step_q  <= div_quo;
	end

	// classification
	assign port_off = port_q - base_port;

	always_comb begin
		push_entry       = '0;
		push_entry.s_lo  = s_lo_q;
		push_entry.s_hi  = s_hi_q;
		push_entry.e_lo  = e_lo_q;
		push_entry.e_hi  = e_hi_q;
		push_entry.step  = step_q;
		push_entry.lim   = lim_q;
		push_entry.first = first_q;
		push_entry.last  = last_q;
		case (cmd_q)
			rps_pkg::CMD_POINT: begin
				push_entry.first = port_off[3:0];
				push_entry.kind  = (port_q < base_port || port_off >= {11'd0, n_act}) ?
					rps_pkg::K_POINT_BAD : rps_pkg::K_POINT;
			end
			rps_pkg::CMD_POP: begin
				push_entry.first = wrk_q;
				push_entry.kind  = ({1'b0, wrk_q} < n_act) ?
					rps_pkg::K_POP : rps_pkg::K_POP_OOR;
			end
			default: begin
				push_entry.kind = (last_q < first_q) ? rps_pkg::K_SCAN_BAD : rps_pkg::K_SCAN;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/rps_fifo.sv
// ----------------------------------------------------------------------------
// rps_fifo
// Small queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rps_pkg::entry_t  push_entry,
	output logic                  full,
	input  wire logic             pop,
	output logic                  nonempty,
	output rps_pkg::entry_t       head
);

	localparam int AW = (rps_pkg::FIFO_DEPTH > 1) ? $clog2(rps_pkg::FIFO_DEPTH) : 1;
	localparam int CW = $clog2(rps_pkg::FIFO_DEPTH + 1);

	rps_pkg::entry_t mem_q [rps_pkg::FIFO_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(rps_pkg::FIFO_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(rps_pkg::FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(rps_pkg::FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_entry;
	end

endmodule

`default_nettype wire

>>> rtl/rps_back.sv
// ----------------------------------------------------------------------------
// rps_back
// Carries out queued words: ring enqueue and pop, one result word per cycle
// while the output is not stalled, scans walk their servers from first to last.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_back #(
	parameter int MAX_SERVERS = rps_pkg::MAX_SERVERS_DEF,
	parameter int QUEUE_SLOTS = rps_pkg::QUEUE_SLOTS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         nonempty,
	input  wire rps_pkg::entry_t head,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [3:0]        server_index,
	output logic [63:0]       sub_start_lo,
	output logic [63:0]       sub_start_hi,
	output logic [63:0]       sub_end_lo,
	output logic [63:0]       sub_end_hi,
	output logic [31:0]       sub_item_limit,
	output logic [2:0]        verdict,
	output logic [7:0]        slot,
	output logic              last_of_run
);

	localparam int DEPTH = (MAX_SERVERS < rps_pkg::RESULT_CAP) ?
		MAX_SERVERS : rps_pkg::RESULT_CAP;
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

	logic [PW-1:0] head_q [DEPTH];
	logic [PW-1:0] tail_q [DEPTH];

	logic        mid_q;
	logic [3:0]  cur_q;
	logic [63:0] cur_lo_q, cur_hi_q;

	logic        fire;
	logic [3:0]  q;
	logic [IW-1:0] qi;
	logic [PW-1:0] h, t, nh, nt;
	logic        is_full, is_empty;
	logic        do_enq, do_deq, scan_end;

	logic [3:0]  r_srv;
	logic [63:0] r_sl, r_sh, r_el, r_eh;
	logic [31:0] r_lim;
	logic [2:0]  r_v;
	logic [7:0]  r_slot;
	logic        r_last;

	assign fire = nonempty && (!out_valid || !out_stall);

	// ring lookup for the server in hand
	assign q  = (head.kind == rps_pkg::K_SCAN && mid_q) ? cur_q : head.first;
	assign qi = IW'(q);
	assign h  = head_q[qi];
	assign t  = tail_q[qi];
	assign nh = (h == PW'(QUEUE_SLOTS - 1)) ? '0 : h + 1'b1;
	assign nt = (t == PW'(QUEUE_SLOTS - 1)) ? '0 : t + 1'b1;
	assign is_full  = (nh == t);
	assign is_empty = (h == t);
	assign scan_end = (q == head.last);

	// result word
	always_comb begin
		r_srv  = q;
		r_sl   = '0;
		r_sh   = '0;
		r_el   = '0;
		r_eh   = '0;
		r_lim  = '0;
		r_v    = rps_pkg::V_ENQ;
		r_slot = '0;
		r_last = 1'b1;
		do_enq = 1'b0;
		do_deq = 1'b0;
		case (head.kind)
			rps_pkg::K_POINT: begin
				do_enq = !is_full;
				r_v    = is_full ? rps_pkg::V_FULL : rps_pkg::V_ENQ;
				r_slot = is_full ? 8'd0 : 8'(h);
			end
			rps_pkg::K_POINT_BAD: begin
				r_srv = '0;
				r_v   = rps_pkg::V_BAD_PORT;
			end
			rps_pkg::K_SCAN: begin
				r_sl   = mid_q ? cur_lo_q : head.s_lo;
				r_sh   = mid_q ? cur_hi_q : head.s_hi;
				r_el   = scan_end ? head.e_lo : r_sl + head.step;
				r_eh   = scan_end ? head.e_hi : head.s_hi;
				r_lim  = head.lim;
				r_last = scan_end;
				do_enq = !is_full;
				r_v    = is_full ? rps_pkg::V_FULL : rps_pkg::V_ENQ;
				r_slot = is_full ? 8'd0 : 8'(h);
			end
			rps_pkg::K_SCAN_BAD: begin
				r_sl  = head.s_lo;
				r_sh  = head.s_hi;
				r_el  = head.e_lo;
				r_eh  = head.e_hi;
				r_lim = head.lim;
				r_v   = rps_pkg::V_BAD_RANGE;
			end
			rps_pkg::K_POP: begin
				do_deq = !is_empty;
				r_v    = is_empty ? rps_pkg::V_EMPTY : rps_pkg::V_POPPED;
				r_slot = is_empty ? 8'd0 : 8'(t);
			end
			default: begin
				r_v = rps_pkg::V_EMPTY;
			end
		endcase
	end

	assign pop = fire && r_last;

	// output register and scan walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			mid_q     <= 1'b0;
			for (int i = 0; i < DEPTH; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			if (fire) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (fire) begin
				mid_q <= !r_last;
				if (do_enq) head_q[qi] <= nh;
				if (do_deq) tail_q[qi] <= nt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cur_q          <= q + 4'd1;
			cur_lo_q       <= r_el;
			cur_hi_q       <= r_eh;
			server_index   <= r_srv;
			sub_start_lo   <= r_sl;
			sub_start_hi   <= r_sh;
			sub_end_lo     <= r_el;
			sub_end_hi     <= r_eh;
			sub_item_limit <= r_lim;
			verdict        <= r_v;
			slot           <= r_slot;
			last_of_run    <= r_last;
		end
	end

endmodule

`default_nettype wire

>>> rtl/rps_checker.sv
// ----------------------------------------------------------------------------
// rps_checker
// Port-level checks of the steering block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] verdict,
	input wire logic [7:0] slot,
	input wire logic       last_of_run
);

	// a stalled word stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(slot))
		else $error("result word dropped or changed under stall");

	// only defined verdicts
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict <= rps_pkg::V_BAD_RANGE)
		else $error("undefined verdict");

	// no slot where nothing was written or read
	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict == rps_pkg::V_FULL || verdict == rps_pkg::V_BAD_PORT ||
		verdict == rps_pkg::V_EMPTY || verdict == rps_pkg::V_BAD_RANGE) |-> slot == 8'd0)
		else $error("slot set on failed access");

	// single-word outcomes end their run
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict == rps_pkg::V_BAD_PORT || verdict == rps_pkg::V_POPPED ||
		verdict == rps_pkg::V_EMPTY || verdict == rps_pkg::V_BAD_RANGE) |-> last_of_run)
		else $error("single result not marked last");

endmodule

bind range_partition_request_steering rps_checker u_rps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.verdict     (verdict),
	.slot        (slot),
	.last_of_run (last_of_run)
);

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives point, scan and pop requests with random idle and stall, predicts
// every result word against a model of the ring queues and checks in order.
// ----------------------------------------------------------------------------
`default_nettype none

// one expected result word
typedef struct {
	logic [3:0]  srv;
	logic [63:0] sl, sh, el, eh;
	logic [31:0] lim;
	logic [2:0]  vd;
	logic [7:0]  sl8;
	logic        lst;
} steer_res_t;

class steer_board;
	logic [4:0]  srv_cnt;
	logic [15:0] base;
	logic [63:0] kps;
	logic [7:0]  head [16];
	logic [7:0]  tail [16];
	steer_res_t  pending [$];
	int          errors;

	function void clear();
		srv_cnt = rps_pkg::SERVER_COUNT_RST;
		base = rps_pkg::BASE_PORT_RST;
		kps = rps_pkg::KEYS_PER_SERVER_RST;
		for (int i = 0; i < 16; i++) begin
			head[i] = 0;
			tail[i] = 0;
		end
		errors = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [63:0] d);
		if (idx == rps_pkg::CFG_SERVER_COUNT) srv_cnt = d[4:0];
		else if (idx == rps_pkg::CFG_BASE_PORT) base = d[15:0];
		else if (idx == rps_pkg::CFG_KEYS_PER_SERVER) kps = d;
	endfunction

	function int active();
		int n;
		n = srv_cnt;
		if (n == 0) n = 1;
		if (n > 16) n = 16;
		return n;
	endfunction

	function int key_srv(logic [63:0] k, int n);
		logic [63:0] q;
		if (kps == 0) return n - 1;
		q = k / kps;
		if (q >= n) return n - 1;
		return int'(q);
	endfunction

	function void put(int s, logic [63:0] a, b, c, d, logic [31:0] l,
			logic [2:0] v, logic [7:0] t, logic f);
		steer_res_t r;
		r.srv = 4'(s); r.sl = a; r.sh = b; r.el = c; r.eh = d;
		r.lim = l; r.vd = v; r.sl8 = t; r.lst = f;
		pending.insert(pending.size(), r);
	endfunction

	// enqueue on ring q; returns verdict, slot through t
	function logic [2:0] push_ring(int q, output logic [7:0] t);
		if (head[q] + 8'd1 == tail[q]) begin
			t = 0;
			return rps_pkg::V_FULL;
		end
		t = head[q];
		head[q] = head[q] + 8'd1;
		return rps_pkg::V_ENQ;
	endfunction

	// note one accepted request word
	function void note_request(logic [1:0] c, logic [15:0] port,
			logic [63:0] slo, shi, elo, ehi, logic [31:0] lim, logic [3:0] w);
		int n, fi, la, p;
		logic [63:0] stp, cl, ch, nl, nh;
		logic [7:0] t;
		logic [2:0] v;
		n = active();
		if (c == rps_pkg::CMD_POINT) begin
			p = int'(port) - int'(base);
			if (p < 0 || p >= n) put(0, 0, 0, 0, 0, 0, rps_pkg::V_BAD_PORT, 0, 1);
			else begin
				v = push_ring(p, t);
				put(p, 0, 0, 0, 0, 0, v, t, 1);
			end
		end else if (c == rps_pkg::CMD_SCAN) begin
			fi = key_srv(slo, n);
			la = key_srv(elo, n);
			if (la < fi) put(fi, slo, shi, elo, ehi, lim, rps_pkg::V_BAD_RANGE, 0, 1);
			else begin
				stp = (elo - slo) / (la - fi + 1);
				cl = slo; ch = shi;
				for (int q = fi; q <= la; q++) begin
					if (q == la) begin nl = elo; nh = ehi; end
					else begin nl = cl + stp; nh = shi; end
					v = push_ring(q, t);
					put(q, cl, ch, nl, nh, lim, v, t, q == la);
					cl = nl; ch = nh;
				end
			end
		end else if (c == rps_pkg::CMD_POP) begin
			if (w < n && head[w] != tail[w]) begin
				put(w, 0, 0, 0, 0, 0, rps_pkg::V_POPPED, tail[w], 1);
				tail[w] = tail[w] + 8'd1;
			end else put(w, 0, 0, 0, 0, 0, rps_pkg::V_EMPTY, 0, 1);
		end
	endfunction

	function void fld(string nm, logic [63:0] e, a);
		if (e !== a) begin
			$display("%0t: %s expected %0h actual %0h", $time, nm, e, a);
			errors++;
		end
	endfunction

	// check one accepted result word
	function void check_result(steer_res_t a);
		steer_res_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected word, expected none actual server %0d", $time, a.srv);
			errors++;
			return;
		end
		e = pending.pop_front();
		fld("server_index", e.srv, a.srv);
		fld("sub_start_lo", e.sl, a.sl);
		fld("sub_start_hi", e.sh, a.sh);
		fld("sub_end_lo", e.el, a.el);
		fld("sub_end_hi", e.eh, a.eh);
		fld("sub_item_limit", e.lim, a.lim);
		fld("verdict", e.vd, a.vd);
		fld("slot", e.sl8, a.sl8);
		fld("last_of_run", e.lst, a.lst);
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// command code the block ignores
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [1:0] cfg_index = 0;
	logic [63:0] cfg_data = 0;
	logic in_valid = 0, in_stall;
	logic [1:0] cmd = 0;
	logic [15:0] dest_port = 0;
	logic [63:0] start_key_lo = 0, start_key_hi = 0, end_key_lo = 0, end_key_hi = 0;
	logic [31:0] item_limit = 0;
	logic [3:0] worker_index = 0;
	logic out_valid, out_stall = 0;
	logic [3:0] server_index;
	logic [63:0] sub_start_lo, sub_start_hi, sub_end_lo, sub_end_hi;
	logic [31:0] sub_item_limit;
	logic [2:0] verdict;
	logic [7:0] slot;
	logic last_of_run;
	logic calm = 0;

	steer_board board = new();

	range_partition_request_steering DUT (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	initial begin
		#50ms;
		$display("range_partition_request_steering verification failed");
		$finish;
	end

	// random output stall, none during calm stretch
	always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 30);

	// collect result words
	always @(posedge clk) begin
		steer_res_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.srv = server_index; r.sl = sub_start_lo; r.sh = sub_start_hi;
			r.el = sub_end_lo; r.eh = sub_end_hi; r.lim = sub_item_limit;
			r.vd = verdict; r.sl8 = slot; r.lst = last_of_run;
			board.check_result(r);
		end
	end

	// valid stays up after a word is taken; the next word or an idle drops it
	task automatic send(logic [1:0] c, logic [15:0] p, logic [63:0] a, b, e, f,
			logic [31:0] l, logic [3:0] w);
		while (!calm && $urandom_range(99) < 30) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; cmd <= c; dest_port <= p; start_key_lo <= a;
		start_key_hi <= b; end_key_lo <= e; end_key_hi <= f;
		item_limit <= l; worker_index <= w;
		do @(posedge clk); while (in_stall);
		if (c != CMD_UNKNOWN) board.note_request(c, p, a, b, e, f, l, w);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] d);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	function automatic logic [63:0] r64();
		return {$urandom, $urandom};
	endfunction

	task automatic rand_item();
		int k;
		logic [63:0] a, e, span;
		k = $urandom_range(99);
		span = board.kps * board.active();
		if (board.kps == 0 || span / board.kps != board.active()) span = 64'hFFFF_FFFF_FFFF_FFFF;
		a = ($urandom_range(3) == 0) ? r64() : r64() % span;
		e = ($urandom_range(3) == 0) ? r64() : r64() % span;
		if (k < 35)
			send(rps_pkg::CMD_POINT, ($urandom_range(4) == 0) ? 16'($urandom)
				: 16'(board.base + $urandom_range(board.active())), 0, 0, 0, 0, 0, 0);
		else if (k < 65)
			send(rps_pkg::CMD_SCAN, 16'($urandom), a, r64(), e, r64(), $urandom, 0);
		else if (k < 97)
			send(rps_pkg::CMD_POP, 0, 0, 0, 0, 0, 0, 4'($urandom_range(board.active())));
		else
			send(CMD_UNKNOWN, 16'($urandom), r64(), r64(), r64(), r64(), $urandom,
				4'($urandom));
	endtask

	initial begin
		board.clear();
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset defaults, extremes and special cases
		send(rps_pkg::CMD_POINT, 16'd1111, 0, 0, 0, 0, 0, 0);
		send(rps_pkg::CMD_POINT, 16'd1110, 0, 0, 0, 0, 0, 0);
		send(rps_pkg::CMD_POINT, 16'hFFFF, 0, 0, 0, 0, 0, 0);
		send(rps_pkg::CMD_POP, 0, 0, 0, 0, 0, 0, 4'd0);
		send(rps_pkg::CMD_POP, 0, 0, 0, 0, 0, 0, 4'd0);
		send(rps_pkg::CMD_POP, 0, 0, 0, 0, 0, 0, 4'hF);
		send(rps_pkg::CMD_SCAN, 0, '1, '1, '1, '1, '1, 0);
		send(CMD_UNKNOWN, '1, '1, '1, '1, '1, '1, '1);
		drain();
		write_reg(rps_pkg::CFG_SERVER_COUNT, 64'd16);
		write_reg(rps_pkg::CFG_BASE_PORT, 64'd0);
		write_reg(rps_pkg::CFG_KEYS_PER_SERVER, 64'd100);
		send(rps_pkg::CMD_SCAN, 0, 64'd5, 64'd7, 64'd1599, 64'd9, 32'hFFFF_FFFF, 0);
		send(rps_pkg::CMD_SCAN, 0, 64'd900, 1, 64'd50, 2, 32'd3, 0);
		send(rps_pkg::CMD_SCAN, 0, 0, 0, '1, '1, 0, 0);
		send(rps_pkg::CMD_POINT, 16'd15, 0, 0, 0, 0, 0, 0);
		send(rps_pkg::CMD_POINT, 16'd16, 0, 0, 0, 0, 0, 0);
		send(rps_pkg::CMD_POP, 0, 0, 0, 0, 0, 0, 4'd15);
		drain();
		write_reg(rps_pkg::CFG_KEYS_PER_SERVER, 64'd0);
		write_reg(rps_pkg::CFG_SERVER_COUNT, 64'd0);
		write_reg(rps_pkg::CFG_BASE_PORT, 64'hFFFF);
		send(rps_pkg::CMD_SCAN, 0, 64'd3, 0, 64'd1, 0, 32'd1, 0);
		send(rps_pkg::CMD_POINT, 16'hFFFF, 0, 0, 0, 0, 0, 0);
		// fill ring 0 to full, pop a few, then wrap the head around to full again
		for (int i = 0; i < 256; i++) send(rps_pkg::CMD_POINT, 16'hFFFF, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 8; i++) send(rps_pkg::CMD_POP, 0, 0, 0, 0, 0, 0, 4'd0);
		for (int i = 0; i < 9; i++) send(rps_pkg::CMD_POINT, 16'hFFFF, 0, 0, 0, 0, 0, 0);
		drain();
		write_reg(rps_pkg::CFG_SERVER_COUNT, 64'd31);
		send(rps_pkg::CMD_POP, 0, 0, 0, 0, 0, 0, 4'd15);
		drain();

		// random phases under several settings, phase 3 without idle or output stall
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(rps_pkg::CFG_SERVER_COUNT, 64'($urandom_range(31)));
			write_reg(rps_pkg::CFG_BASE_PORT, (ph == 5) ? 64'd0 : 64'($urandom));
			write_reg(rps_pkg::CFG_KEYS_PER_SERVER, (ph == 0) ? 64'd0
				: (ph == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : (ph == 2) ? 64'd1 : r64() >> $urandom_range(63));
			calm = (ph == 3);
			for (int i = 0; i < ((ph == 3) ? 40 : 18); i++) rand_item();
			calm = 0;
			drain();
		end

		if (board.errors == 0)
			$display("range_partition_request_steering verification clean");
		else
			$display("range_partition_request_steering verification failed");
		$finish;
	end
endmodule

`default_nettype wire
